/* sv/mta_pkg.sv */
// Shared types, constants and fp32 helper functions for the masked tile
// weighted-sum accumulate core. No dependencies.
package mta_pkg;

  localparam int TILE_ROWS = 8;
  localparam int TILE_COLS = 64;
  localparam int HEAD_DIM  = 64;

  localparam int ROW_W  = $clog2(TILE_ROWS);
  localparam int COL_W  = $clog2(TILE_COLS);
  localparam int DIM_W  = $clog2(HEAD_DIM);
  localparam int ACC_AW = ROW_W + DIM_W;
  localparam int W_AW   = ROW_W + COL_W;
  localparam int V_AW   = COL_W + DIM_W;
  localparam int ACC_DEPTH = TILE_ROWS * HEAD_DIM;

  localparam logic [1:0] KIND_LOAD_W  = 2'd0;
  localparam logic [1:0] KIND_LOAD_V  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_ACTIVE_ROWS = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_COLS = 2'd1;
  localparam logic [1:0] CFG_CLEAR_MODE  = 2'd2;

  localparam logic [31:0] FP_QNAN = 32'hFFC0_0000;

  typedef struct packed {
    logic             we_w;
    logic             we_v;
    logic [W_AW-1:0]  w_addr;
    logic [V_AW-1:0]  v_addr;
    logic [31:0]      data;
  } tile_wr_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [DIM_W-1:0] dim;
  } tile_rd_t;

  function automatic logic [31:0] fp_quiet(input logic [31:0] x);
    return {x[31:23], 1'b1, x[21:0]};
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != '0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == '0);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] x);
    return x[30:0] == '0;
  endfunction

  // count of leading zeros over a 51-bit word
  function automatic logic [5:0] fp_lzc(input logic [50:0] v);
    logic [5:0] n;
    logic       found;
    n = '0;
    found = 1'b0;
    for (int i = 50; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // m has its leading one at bit 49 for a normal result; value is
  // m / 2^49 * 2^(be - 127). Round to nearest even and pack.
  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [10:0] be,
                                           input logic [49:0] m);
    logic [49:0]       ms;
    logic [10:0]       sh;
    logic              lost;
    logic [7:0]        ef;
    logic              g;
    logic              st;
    logic              inc;
    logic [30:0]       mag;
    if (be >= 11'sd255) begin
      return {sgn, 8'hFF, 23'd0};
    end
    if (be <= 11'sd0) begin
      sh   = 11'd1 - 11'(be);
      ms   = m >> sh;
      lost = |(m & ~({50{1'b1}} << sh));
      ms[0] = ms[0] | lost;
      ef   = 8'd0;
    end else begin
      ms = m;
      ef = be[7:0];
    end
    g   = ms[25];
    st  = |ms[24:0];
    inc = g & (st | ms[26]);
    mag = {ef, ms[48:26]} + 31'(inc);
    return {sgn, mag};
  endfunction

endpackage

/* sv/mta_tile_mem.sv */
// Weight and value tile memories: one write and one registered read each.
// Depends on mta_pkg.
module mta_tile_mem import mta_pkg::*; (
  input  logic        clk,
  input  tile_wr_t    wr,
  input  tile_rd_t    rd,
  output logic [31:0] w_q,
  output logic [31:0] v_q
);

  logic [31:0] wmem [TILE_ROWS*TILE_COLS];
  logic [31:0] vmem [TILE_COLS*HEAD_DIM];

  always_ff @(posedge clk) begin
    if (wr.we_w) wmem[wr.w_addr] <= wr.data;
    if (rd.en) w_q <= wmem[{rd.row, rd.col}];
  end

  always_ff @(posedge clk) begin
    if (wr.we_v) vmem[wr.v_addr] <= wr.data;
    if (rd.en) v_q <= vmem[{rd.col, rd.dim}];
  end

endmodule

/* sv/mta_fp_mul.sv */
// Two-stage fp32 multiplier, round to nearest even, free running.
// Depends on mta_pkg.
module mta_fp_mul import mta_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic               spec1;
  logic [31:0]        sres1;
  logic               sgn1;
  logic signed [10:0] be1;
  logic [47:0]        p1;

  logic        sgn;
  logic [7:0]  eae;
  logic [7:0]  ebe;
  logic [23:0] ma;
  logic [23:0] mb;
  logic        spec;
  logic [31:0] sres;

  always_comb begin
    sgn  = a[31] ^ b[31];
    eae  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    ebe  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma   = {(a[30:23] != 8'd0), a[22:0]};
    mb   = {(b[30:23] != 8'd0), b[22:0]};
    spec = 1'b1;
    sres = '0;
    if (fp_is_nan(a)) sres = fp_quiet(a);
    else if (fp_is_nan(b)) sres = fp_quiet(b);
    else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) sres = FP_QNAN;
    else if (fp_is_inf(a) || fp_is_inf(b)) sres = {sgn, 8'hFF, 23'd0};
    else if (fp_is_zero(a) || fp_is_zero(b)) sres = {sgn, 31'd0};
    else spec = 1'b0;
  end

  always_ff @(posedge clk) begin
    spec1 <= spec;
    sres1 <= sres;
    sgn1  <= sgn;
    be1   <= $signed(11'(eae) + 11'(ebe) - 11'd126);
    p1    <= ma * mb;
  end

  logic [5:0]  lz;
  logic [50:0] n;

  always_comb begin
    lz = fp_lzc({p1, 3'b000});
    n  = {p1, 3'b000} << lz;
  end

  always_ff @(posedge clk) begin
    p <= spec1 ? sres1 : fp_round(sgn1, be1 - $signed(11'(lz)), {n[50:2], n[1] | n[0]});
  end

endmodule

/* sv/mta_fp_add.sv */
// Two-stage fp32 adder, round to nearest even. The result register holds
// until the next operation, and clr loads it with +0.0. Depends on mta_pkg.
module mta_fp_add import mta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        clr,
  input  logic        in_v,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);

  logic        v1;
  logic        spec1;
  logic [31:0] sres1;
  logic        s1;
  logic        sub1;
  logic [7:0]  e1;
  logic [50:0] x1;
  logic [50:0] x2;

  logic        swap;
  logic [31:0] big;
  logic [31:0] sml;
  logic [7:0]  eb;
  logic [7:0]  es;
  logic [7:0]  d;
  logic [50:0] pre;
  logic        lost;
  logic        spec;
  logic [31:0] sres;

  always_comb begin
    swap = b[30:0] > a[30:0];
    big  = swap ? b : a;
    sml  = swap ? a : b;
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d    = eb - es;
    pre  = {1'b0, (sml[30:23] != 8'd0), sml[22:0], 26'd0};
    lost = |(pre & ~({51{1'b1}} << d));
    spec = 1'b1;
    sres = '0;
    if (fp_is_nan(a)) sres = fp_quiet(a);
    else if (fp_is_nan(b)) sres = fp_quiet(b);
    else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) sres = FP_QNAN;
    else if (fp_is_inf(a)) sres = a;
    else if (fp_is_inf(b)) sres = b;
    else spec = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_v;
  end

  always_ff @(posedge clk) begin
    if (in_v) begin
      spec1 <= spec;
      sres1 <= sres;
      s1    <= big[31];
      sub1  <= a[31] ^ b[31];
      e1    <= eb;
      x1    <= {1'b0, (big[30:23] != 8'd0), big[22:0], 26'd0};
      x2    <= (pre >> d) | 51'(lost);
    end
  end

  logic [50:0] sum;
  logic [5:0]  lz;
  logic [50:0] n;

  always_comb begin
    sum = sub1 ? (x1 - x2) : (x1 + x2);
    lz  = fp_lzc(sum);
    n   = sum << lz;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      s <= '0;
    end else if (v1) begin
      if (spec1) s <= sres1;
      else if (sum == '0) s <= {s1 & ~sub1, 31'd0};
      else s <= fp_round(s1, $signed(11'(e1) + 11'd1 - 11'(lz)), {n[50:2], n[1] | n[0]});
    end
  end

endmodule

/* sv/masked_tile_weighted_sum_accumulate_core.sv */
// Attention output tile engine (fp32, round to nearest even). A load, or a compute
// whose index lies outside the tile, is taken in idle and gives no result. A
// compute for an inactive row goes straight to the result state. For an active
// row the column walk covers active_cols, capped at the tile width, issuing a
// multiply on alternate phases, a pace set by the fp adder that carries the
// running sum; a drain and an accumulator read-add-write follow (clear mode adds
// zero in place of the stored value).
// One compute is in flight at a time; a finished result sits in the output
// register while the next transaction is taken. After reset all 512 accumulator
// entries are cleared, and meanwhile no transaction is accepted.
module masked_tile_weighted_sum_accumulate_core import mta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  first_index,
  input  logic [5:0]  second_index,
  input  logic [31:0] element_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_row,
  output logic [5:0]  out_dim,
  output logic [31:0] out_value,
  output logic        row_active
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_ISSUE = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_ACC   = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_RES   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [3:0] active_rows;
  logic [6:0] active_cols;
  logic       clear_mode;
  logic [3:0] rows_eff;
  logic [6:0] cols_eff;

  logic [ROW_W-1:0]  row;
  logic [DIM_W-1:0]  dim;
  logic              act;
  logic [COL_W:0]    col;
  logic              ph;
  logic [1:0]        wcnt;
  logic [ACC_AW-1:0] clr_addr;
  logic [2:0]        iss_d;

  logic [31:0] acc_mem [ACC_DEPTH];
  logic [31:0] acc_q;

  tile_wr_t    wr;
  tile_rd_t    rd;
  logic [31:0] w_q;
  logic [31:0] v_q;
  logic [31:0] prod;
  logic [31:0] add_s;
  logic        add_clr;
  logic        add_in_v;
  logic        fin_go;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        in_acc;
  logic        cmp_go;
  logic        cmp_act;
  logic        res_go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= 4'd8;
      active_cols <= 7'd64;
      clear_mode  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_ROWS: active_rows <= cfg_data[3:0];
        CFG_ACTIVE_COLS: active_cols <= cfg_data;
        CFG_CLEAR_MODE:  clear_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign rows_eff = (active_rows > 4'(TILE_ROWS)) ? 4'(TILE_ROWS) : active_rows;
  assign cols_eff = (active_cols > 7'(TILE_COLS)) ? 7'(TILE_COLS) : active_cols;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cmp_go   = in_acc && (kind == KIND_COMPUTE) &&
                    ({1'b0, first_index} < 7'(TILE_ROWS)) &&
                    ({1'b0, second_index} < 7'(HEAD_DIM));
  assign cmp_act  = {2'b00, first_index} < {4'd0, rows_eff};
  assign res_go   = (state == ST_RES) && (!out_valid || out_ready);

  always_comb begin
    wr.we_w   = 1'b0;
    wr.we_v   = 1'b0;
    wr.w_addr = {first_index[ROW_W-1:0], second_index[COL_W-1:0]};
    wr.v_addr = {first_index[COL_W-1:0], second_index[DIM_W-1:0]};
    wr.data   = element_value;
    if (in_acc) begin
      case (kind)
        KIND_LOAD_W: wr.we_w = ({1'b0, first_index} < 7'(TILE_ROWS)) &&
                               ({1'b0, second_index} < 7'(TILE_COLS));
        KIND_LOAD_V: wr.we_v = ({1'b0, first_index} < 7'(TILE_COLS)) &&
                               ({1'b0, second_index} < 7'(HEAD_DIM));
        default: ;
      endcase
    end
  end

  // issue a column read on the even phase while columns remain
  always_comb begin
    rd.en  = (state == ST_ISSUE) && !ph && (7'(col) != cols_eff);
    rd.row = row;
    rd.col = col[COL_W-1:0];
    rd.dim = dim;
  end

  mta_tile_mem u_mem (
    .clk (clk),
    .wr  (wr),
    .rd  (rd),
    .w_q (w_q),
    .v_q (v_q)
  );

  mta_fp_mul u_mul (
    .clk (clk),
    .a   (w_q),
    .b   (v_q),
    .p   (prod)
  );

  assign fin_go   = (state == ST_FIN) && (wcnt == 2'd0);
  assign add_clr  = cmp_go;
  assign add_in_v = iss_d[2] || fin_go;
  assign add_a    = fin_go ? (clear_mode ? 32'd0 : acc_q) : add_s;
  assign add_b    = fin_go ? add_s : prod;

  mta_fp_add u_add (
    .clk  (clk),
    .rst  (rst),
    .clr  (add_clr),
    .in_v (add_in_v),
    .a    (add_a),
    .b    (add_b),
    .s    (add_s)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == ACC_AW'(ACC_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (cmp_go) state_next = cmp_act ? ST_ISSUE : ST_RES;
      ST_ISSUE: if (!ph && (7'(col) == cols_eff)) state_next = ST_DRAIN;
      ST_DRAIN: if (wcnt == 2'd2) state_next = ST_ACC;
      ST_ACC:   state_next = ST_FIN;
      ST_FIN:   if (wcnt == 2'd1) state_next = ST_RES;
      ST_RES:   if (res_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      iss_d    <= '0;
      col      <= '0;
      ph       <= 1'b0;
      wcnt     <= '0;
    end else begin
      state <= state_next;
      iss_d <= {iss_d[1:0], rd.en};
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cmp_go) begin
        col <= '0;
        ph  <= 1'b0;
      end else if (state == ST_ISSUE) begin
        ph <= ~ph;
        if (rd.en) col <= col + 1'b1;
      end
      if (state != state_next) wcnt <= '0;
      else wcnt <= wcnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_go) begin
      row <= first_index[ROW_W-1:0];
      dim <= second_index[DIM_W-1:0];
      act <= cmp_act;
    end
  end

  // accumulator memory: clearing pass, read before the final add, write back
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) acc_mem[clr_addr] <= '0;
    else if (res_go && act) acc_mem[{row, dim}] <= add_s;
    if (state == ST_ACC) acc_q <= acc_mem[{row, dim}];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_go) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_go) begin
      out_row    <= 3'(row);
      out_dim    <= 6'(dim);
      out_value  <= act ? add_s : 32'd0;
      row_active <= act;
    end
  end

  a_rise_from_res: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RES))
    else $error("result appeared without a finished compute");

  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !row_active |-> out_value == 32'd0)
    else $error("inactive row carries a nonzero value");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> iss_d == 3'd0)
    else $error("product still in flight at final add");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ISSUE |-> 7'(col) <= cols_eff)
    else $error("column walk ran past the active count");

  a_acc_active: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> act)
    else $error("accumulator read for an inactive row");

endmodule
